/* rtl/core/lca_binary_lifting_engine_macros.svh */
// ----------------------------------------------------------------------------
// LCA binary-lifting engine: assertion macros
// Shared property shorthands, clocked on clk and disabled during arst_n low.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_ENGINE_MACROS_SVH
`define LCA_BINARY_LIFTING_ENGINE_MACROS_SVH

// Same-cycle implication
`define LCABL_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LCABL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lcabl_pkg.sv */
// ----------------------------------------------------------------------------
// LCA binary-lifting engine: shared package
// Sizes, entry and request types, sequencer states and the table address map.
// ----------------------------------------------------------------------------
`default_nettype none

package lcabl_pkg;

	localparam int NODES     = 1024;
	localparam int LEVELS    = 10;
	localparam int NODE_W    = 10;
	localparam int DEPTH_W   = 10;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int TBL_DEPTH = NODES * LEVELS;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(LEVELS - 1);

	typedef enum logic {
		OP_ATTACH = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	// One lifting-table entry: valid flag plus ancestor node
	typedef struct packed {
		logic              ok;
		logic [NODE_W-1:0] node;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_RDP,
		ST_A_WR0,
		ST_A_RD,
		ST_A_WR,
		ST_Q_RDA,
		ST_Q_RDB,
		ST_Q_CMP,
		ST_L1_T,
		ST_L1_D,
		ST_L1_C,
		ST_Q_EQ,
		ST_L2_U,
		ST_L2_V,
		ST_L2_C,
		ST_Q_FIN,
		ST_Q_FINC,
		ST_OUT
	} state_t;

	// Sequencer to storage
	typedef struct packed {
		logic               tbl_we;
		logic [TBL_AW-1:0]  tbl_waddr;
		entry_t             tbl_wdata;
		logic [TBL_AW-1:0]  tbl_raddr;
		logic               nd_we;
		logic [NODE_W-1:0]  nd_waddr;
		logic [DEPTH_W-1:0] depth_wdata;
		logic [NODE_W-1:0]  tag_wdata;
		logic [NODE_W-1:0]  nd_raddr;
	} mem_req_t;

	// Storage to sequencer, registered read data
	typedef struct packed {
		entry_t             tbl;
		logic [DEPTH_W-1:0] depth;
		logic [NODE_W-1:0]  tag;
	} mem_rsp_t;

	// Finished query result
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [NODE_W-1:0] anc;
	} res_t;

	// Row-major table address: node * LEVELS + level
	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] node,
			input logic [LVL_W-1:0] lvl);
		return TBL_AW'(node) * TBL_AW'(LEVELS) + TBL_AW'(lvl);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lca_binary_lifting_engine.sv */
// ----------------------------------------------------------------------------
// LCA binary-lifting engine: top level
// Keeps a forest as a binary-lifting table; attaches nodes and answers
// lowest-common-ancestor queries.
//
//   Channel  Dir  Handshake          Word contents
//   s_*      in   s_tvalid/s_tready  tdata: node_a, node_b; tuser: op, has_parent
//   m_*      out  m_tvalid/m_tready  tdata: ancestor; tuser: found
//
// One word at a time; s_tready is high only while the sequencer is idle.
// Attach: one table write for level 0, then one table read and one write per higher level.
// Query: ends early when the components differ; otherwise each of the two lifts
// does two table/depth reads and one compare per level.
// Reset clears the sequencer and output valid; storage is not cleared.
// A stalled m_tready holds the result; a new word is taken once it is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lca_binary_lifting_engine_macros.svh"

module lca_binary_lifting_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lcabl_pkg::IN_DATA_W-1:0]   s_tdata,   // node_a, node_b, zero pad
	input  wire logic [lcabl_pkg::IN_USER_W-1:0]   s_tuser,   // op, has_parent
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [lcabl_pkg::OUT_DATA_W-1:0]       m_tdata,   // ancestor, zero pad
	output logic                                   m_tuser    // found
);

	lcabl_pkg::res_t               res;
	logic                          res_ready;
	logic                          res_load;
	logic                          m_tvalid_q;
	logic                          found_q;
	logic [lcabl_pkg::NODE_W-1:0]  anc_q;

	lcabl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_a      (s_tdata[lcabl_pkg::NODE_W-1:0]),
		.in_b      (s_tdata[2*lcabl_pkg::NODE_W-1:lcabl_pkg::NODE_W]),
		.in_hp     (s_tuser[1]),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: free when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;
	assign res_load  = res.valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q <= res.found;
			anc_q   <= res.anc;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = lcabl_pkg::OUT_DATA_W'(anc_q);

	`LCABL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`LCABL_ASSERT_IMPLY(a_res_not_idle, res.valid, !s_tready, "result pending while idle")
	`LCABL_ASSERT_NEXT(a_load_shows, res_load, m_tvalid, "loaded result not shown")
	`LCABL_ASSERT_IMPLY(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with ancestor")

endmodule

`default_nettype wire

/* rtl/core/lcabl_store.sv */
// ----------------------------------------------------------------------------
// LCA binary-lifting engine: node storage
// Lifting table plus per-node depth and component tag, one write and one
// registered read each per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcabl_store (
	input  wire logic              clk,
	input  wire lcabl_pkg::mem_req_t req,
	output lcabl_pkg::mem_rsp_t    rsp
);

	lcabl_pkg::entry_t             tbl_mem   [lcabl_pkg::TBL_DEPTH];
	logic [lcabl_pkg::DEPTH_W-1:0] depth_mem [lcabl_pkg::NODES];
	logic [lcabl_pkg::NODE_W-1:0]  tag_mem   [lcabl_pkg::NODES];

	// Ancestor table, then depth and component tag on a shared address
	always_ff @(posedge clk) begin
		if (req.tbl_we) begin
			tbl_mem[req.tbl_waddr] <= req.tbl_wdata;
		end
		rsp.tbl <= tbl_mem[req.tbl_raddr];
		if (req.nd_we) begin
			depth_mem[req.nd_waddr] <= req.depth_wdata;
			tag_mem[req.nd_waddr]   <= req.tag_wdata;
		end
		rsp.depth <= depth_mem[req.nd_raddr];
		rsp.tag   <= tag_mem[req.nd_raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/lcabl_ctrl.sv */
// ----------------------------------------------------------------------------
// LCA binary-lifting engine: sequencer
// Walks the lifting table one level per step for attach fills and both
// query lifts, using table reads, plus a depth read and compare in the first lift.
// ----------------------------------------------------------------------------
`default_nettype none

module lcabl_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        in_op,
	input  wire logic [lcabl_pkg::NODE_W-1:0] in_a,
	input  wire logic [lcabl_pkg::NODE_W-1:0] in_b,
	input  wire logic                        in_hp,
	input  wire logic                        res_ready,
	output lcabl_pkg::res_t                  res
);

	lcabl_pkg::state_t state_q, state_d;

	logic [lcabl_pkg::NODE_W-1:0]  a_q, a_d, b_q, b_d, u_q, u_d, v_q, v_d;
	logic [lcabl_pkg::NODE_W-1:0]  ta_q, ta_d, anc_q, anc_d;
	logic [lcabl_pkg::DEPTH_W-1:0] da_q, da_d, dv_q, dv_d;
	logic [lcabl_pkg::LVL_W-1:0]   lvl_q, lvl_d;
	logic                          hp_q, hp_d, found_q, found_d;
	lcabl_pkg::entry_t             cur_q, cur_d, ent_q, ent_d, fill;
	lcabl_pkg::mem_req_t           req;
	lcabl_pkg::mem_rsp_t           rsp;

	lcabl_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcabl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		a_q     <= a_d;
		b_q     <= b_d;
		hp_q    <= hp_d;
		u_q     <= u_d;
		v_q     <= v_d;
		ta_q    <= ta_d;
		da_q    <= da_d;
		dv_q    <= dv_d;
		lvl_q   <= lvl_d;
		cur_q   <= cur_d;
		ent_q   <= ent_d;
		found_q <= found_d;
		anc_q   <= anc_d;
	end

	// Next state, storage requests and datapath updates
	always_comb begin
		state_d = state_q;
		a_d     = a_q;
		b_d     = b_q;
		hp_d    = hp_q;
		u_d     = u_q;
		v_d     = v_q;
		ta_d    = ta_q;
		da_d    = da_q;
		dv_d    = dv_q;
		lvl_d   = lvl_q;
		cur_d   = cur_q;
		ent_d   = ent_q;
		found_d = found_q;
		anc_d   = anc_q;
		fill    = '0;
		in_ready = 1'b0;

		req             = '0;
		req.nd_raddr    = b_q;
		req.tbl_raddr   = lcabl_pkg::tbl_addr(u_q, lvl_q);
		req.tbl_waddr   = lcabl_pkg::tbl_addr(a_q, lvl_q);
		req.nd_waddr    = a_q;

		case (state_q)
			lcabl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					a_d  = in_a;
					b_d  = in_b;
					hp_d = in_hp;
					state_d = (in_op == lcabl_pkg::OP_QUERY) ? lcabl_pkg::ST_Q_RDA
						: lcabl_pkg::ST_A_RDP;
				end
			end

			// Attach: fetch the parent's depth and tag
			lcabl_pkg::ST_A_RDP: begin
				req.nd_raddr = b_q;
				state_d = lcabl_pkg::ST_A_WR0;
			end

			// Attach: write depth, tag and the level-0 entry
			lcabl_pkg::ST_A_WR0: begin
				req.nd_we = 1'b1;
				req.tbl_we = 1'b1;
				req.tbl_waddr = lcabl_pkg::tbl_addr(a_q, '0);
				if (hp_q) begin
					req.depth_wdata = (rsp.depth == lcabl_pkg::DEPTH_MAX) ? lcabl_pkg::DEPTH_MAX
						: rsp.depth + lcabl_pkg::DEPTH_W'(1);
					req.tag_wdata = rsp.tag;
					fill.ok   = 1'b1;
					fill.node = b_q;
				end else begin
					req.depth_wdata = '0;
					req.tag_wdata   = a_q;
				end
				req.tbl_wdata = fill;
				cur_d = fill;
				lvl_d = lcabl_pkg::LVL_W'(1);
				state_d = (lcabl_pkg::LEVELS == 1) ? lcabl_pkg::ST_IDLE : lcabl_pkg::ST_A_RD;
			end

			// Attach: read the previous ancestor's row one level down
			lcabl_pkg::ST_A_RD: begin
				req.tbl_raddr = lcabl_pkg::tbl_addr(cur_q.node, lvl_q - lcabl_pkg::LVL_W'(1));
				state_d = lcabl_pkg::ST_A_WR;
			end

			// Attach: store the doubled jump, or mark it absent
			lcabl_pkg::ST_A_WR: begin
				fill = cur_q.ok ? rsp.tbl : '0;
				req.tbl_we = 1'b1;
				req.tbl_waddr = lcabl_pkg::tbl_addr(a_q, lvl_q);
				req.tbl_wdata = fill;
				cur_d = fill;
				if (lvl_q == lcabl_pkg::LVL_LAST) begin
					state_d = lcabl_pkg::ST_IDLE;
				end else begin
					lvl_d = lvl_q + lcabl_pkg::LVL_W'(1);
					state_d = lcabl_pkg::ST_A_RD;
				end
			end

			// Query: fetch both nodes' depth and tag
			lcabl_pkg::ST_Q_RDA: begin
				req.nd_raddr = a_q;
				state_d = lcabl_pkg::ST_Q_RDB;
			end

			lcabl_pkg::ST_Q_RDB: begin
				req.nd_raddr = b_q;
				da_d = rsp.depth;
				ta_d = rsp.tag;
				state_d = lcabl_pkg::ST_Q_CMP;
			end

			// Query: drop on component mismatch, else order by depth
			lcabl_pkg::ST_Q_CMP: begin
				if (ta_q != rsp.tag) begin
					found_d = 1'b0;
					anc_d   = '0;
					state_d = lcabl_pkg::ST_OUT;
				end else begin
					if (da_q < rsp.depth) begin
						u_d  = b_q;
						v_d  = a_q;
						dv_d = da_q;
					end else begin
						u_d  = a_q;
						v_d  = b_q;
						dv_d = rsp.depth;
					end
					lvl_d = lcabl_pkg::LVL_LAST;
					state_d = lcabl_pkg::ST_L1_T;
				end
			end

			// Lift the deeper node: read its entry at this level
			lcabl_pkg::ST_L1_T: begin
				req.tbl_raddr = lcabl_pkg::tbl_addr(u_q, lvl_q);
				state_d = lcabl_pkg::ST_L1_D;
			end

			// Fetch the jump target's depth
			lcabl_pkg::ST_L1_D: begin
				ent_d = rsp.tbl;
				req.nd_raddr = rsp.tbl.node;
				state_d = lcabl_pkg::ST_L1_C;
			end

			// Take the jump if it does not pass the shallower node
			lcabl_pkg::ST_L1_C: begin
				if (ent_q.ok && (rsp.depth >= dv_q)) begin
					u_d = ent_q.node;
				end
				if (lvl_q == '0) begin
					state_d = lcabl_pkg::ST_Q_EQ;
				end else begin
					lvl_d = lvl_q - lcabl_pkg::LVL_W'(1);
					state_d = lcabl_pkg::ST_L1_T;
				end
			end

			lcabl_pkg::ST_Q_EQ: begin
				if (u_q == v_q) begin
					found_d = 1'b1;
					anc_d   = u_q;
					state_d = lcabl_pkg::ST_OUT;
				end else begin
					lvl_d = lcabl_pkg::LVL_LAST;
					state_d = lcabl_pkg::ST_L2_U;
				end
			end

			// Lift both while their ancestors differ
			lcabl_pkg::ST_L2_U: begin
				req.tbl_raddr = lcabl_pkg::tbl_addr(u_q, lvl_q);
				state_d = lcabl_pkg::ST_L2_V;
			end

			lcabl_pkg::ST_L2_V: begin
				ent_d = rsp.tbl;
				req.tbl_raddr = lcabl_pkg::tbl_addr(v_q, lvl_q);
				state_d = lcabl_pkg::ST_L2_C;
			end

			lcabl_pkg::ST_L2_C: begin
				if (ent_q.ok && rsp.tbl.ok && (ent_q.node != rsp.tbl.node)) begin
					u_d = ent_q.node;
					v_d = rsp.tbl.node;
				end
				if (lvl_q == '0) begin
					state_d = lcabl_pkg::ST_Q_FIN;
				end else begin
					lvl_d = lvl_q - lcabl_pkg::LVL_W'(1);
					state_d = lcabl_pkg::ST_L2_U;
				end
			end

			// Answer is the parent of the lifted node, if any
			lcabl_pkg::ST_Q_FIN: begin
				req.tbl_raddr = lcabl_pkg::tbl_addr(u_q, '0);
				state_d = lcabl_pkg::ST_Q_FINC;
			end

			lcabl_pkg::ST_Q_FINC: begin
				found_d = rsp.tbl.ok;
				anc_d   = rsp.tbl.ok ? rsp.tbl.node : '0;
				state_d = lcabl_pkg::ST_OUT;
			end

			// Hold the result until the output register takes it
			lcabl_pkg::ST_OUT: begin
				if (res_ready) begin
					state_d = lcabl_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = lcabl_pkg::ST_IDLE;
			end
		endcase
	end

	assign res.valid = (state_q == lcabl_pkg::ST_OUT);
	assign res.found = found_q;
	assign res.anc   = anc_q;

endmodule

`default_nettype wire
